@@ hdl/lfpl_pkg.sv @@
`timescale 1ns / 1ps

package lfpl_pkg;

  // one pixel word on the input side
  typedef struct packed {
    logic [23:0] pixel_color;
    logic        last_pixel;
    logic [7:0]  desired_brightness;
  } in_item_t;

  // one result word
  typedef struct packed {
    logic [7:0]  allowed_brightness;
    logic [17:0] estimated_ma;
    logic        was_clamped;
  } out_item_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [15:0] budget_ma;
    logic [9:0]  channel_full_current;
    logic [7:0]  idle_current_per_led;
  } cfg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_FULL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE      = 2'd2;

  localparam logic [15:0] RST_BUDGET    = 16'd2000;
  localparam logic [9:0]  RST_CHAN_FULL = 10'd320;
  localparam logic [7:0]  RST_IDLE      = 8'd16;

  // 255 squared, brightness times channel value scale
  localparam logic [15:0] SCALE2     = 16'd65025;
  localparam logic [17:0] SCALE2_X2  = 18'd130050;
  // 16 * 65025 and half of it, for rounding to whole mA
  localparam logic [19:0] EST_DEN    = 20'd1040400;
  localparam logic [19:0] EST_HALF   = 20'd520200;
  // floor(2^40 / 65025), gives a quotient by 65025 that is low by at most two
  localparam logic [24:0] EST_RECIP  = 25'd16909060;
  localparam logic [17:0] EST_MAX    = 18'h3FFFF;
  localparam logic [7:0]  MAX_BRIGHT = 8'hFF;

  // depth of the frame job queue, a power of two
  localparam int JOB_DEPTH = 2;

endpackage

@@ hdl/lfpl_div.sv @@
`timescale 1ns / 1ps

module lfpl_div #(
  parameter int DVD_W = 40,
  parameter int DEN_W = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dsr_r, dsr_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  // restoring division, one quotient bit per cycle shifted into dvd_r
  assign trial     = {rem_r, dvd_r[DVD_W-1]};
  assign ge        = (trial >= {1'b0, dsr_r});
  assign trial_sub = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ hdl/lfpl_front.sv @@
`timescale 1ns / 1ps

module lfpl_front #(
  parameter int MAX_PIXELS = 1024,
  parameter int CNT_W      = 11,
  parameter int SUM_W      = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  lfpl_pkg::in_item_t in_item,
  output logic             job_valid,
  input  logic             job_ready,
  output logic [CNT_W-1:0] job_n,
  output logic [SUM_W-1:0] job_s,
  output logic [7:0]       job_d
);
  import lfpl_pkg::*;

  localparam int PTR_W  = $clog2(JOB_DEPTH);
  localparam int QCNT_W = $clog2(JOB_DEPTH + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  q_n_r [JOB_DEPTH];
  logic [SUM_W-1:0]  q_s_r [JOB_DEPTH];
  logic [7:0]        q_d_r [JOB_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic              in_acc, room, q_push, q_pop;
  logic [SUM_W-1:0]  chan_sum, cur_sum;
  logic [CNT_W-1:0]  cur_cnt;

  assign in_full = (qcnt_r == QCNT_W'(JOB_DEPTH));
  assign in_acc  = in_push && !in_full;

  assign chan_sum = SUM_W'(in_item.pixel_color[23:16]) + SUM_W'(in_item.pixel_color[15:8])
                  + SUM_W'(in_item.pixel_color[7:0]);

  // pixels past the frame limit are dropped from the totals
  assign room    = (cnt_r < CNT_W'(MAX_PIXELS));
  assign cur_cnt = room ? cnt_r + CNT_W'(1) : cnt_r;
  assign cur_sum = room ? sum_r + chan_sum : sum_r;

  assign q_push = in_acc && in_item.last_pixel;
  assign q_pop  = job_valid && job_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (in_acc) begin
      if (in_item.last_pixel) begin
        cnt_nxt = '0;
        sum_nxt = '0;
      end else begin
        cnt_nxt = cur_cnt;
        sum_nxt = cur_sum;
      end
    end
    qcnt_nxt = qcnt_r;
    if (q_push && !q_pop) begin
      qcnt_nxt = qcnt_r + QCNT_W'(1);
    end else if (q_pop && !q_push) begin
      qcnt_nxt = qcnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sum_r    <= '0;
      qcnt_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      qcnt_r <= qcnt_nxt;
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
    if (q_push) begin
      q_n_r[wr_ptr_r] <= cur_cnt;
      q_s_r[wr_ptr_r] <= cur_sum;
      q_d_r[wr_ptr_r] <= in_item.desired_brightness;
    end
  end

  assign job_valid = (qcnt_r != '0);
  assign job_n     = q_n_r[rd_ptr_r];
  assign job_s     = q_s_r[rd_ptr_r];
  assign job_d     = q_d_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCNT_W'(JOB_DEPTH))
    else $error("job queue count above depth");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (cnt_r == '0) && (sum_r == '0))
    else $error("frame totals not cleared after last pixel");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PIXELS))
    else $error("pixel count above frame limit");
`endif

endmodule

@@ hdl/lfpl_back.sv @@
`timescale 1ns / 1ps

module lfpl_back #(
  parameter int CNT_W = 11,
  parameter int SUM_W = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lfpl_pkg::cfg_t     cfg,
  input  logic               job_valid,
  output logic               job_ready,
  input  logic [CNT_W-1:0]   job_n,
  input  logic [SUM_W-1:0]   job_s,
  input  logic [7:0]         job_d,
  output logic               res_valid,
  input  logic               res_pop,
  output lfpl_pkg::out_item_t res_item
);
  import lfpl_pkg::*;

  localparam int IDLE_W = CNT_W + 8;
  localparam int CF_W   = SUM_W + 10;
  localparam int P1_W   = IDLE_W + 16;
  localparam int P2_W   = CF_W + 8;
  localparam int PMAX_W = (P1_W > P2_W) ? P1_W : P2_W;
  localparam int NUM_W  = PMAX_W + 2;
  localparam int N2_W   = 36;
  localparam int DVD_W  = N2_W;
  localparam int DEN_W  = CF_W;
  localparam int CMP_W  = (IDLE_W > 20) ? IDLE_W : 20;
  localparam int ZT_W   = NUM_W - 20;
  localparam int RP_W   = ZT_W + 25;
  localparam int Q_W    = (NUM_W - 19 > 18) ? NUM_W - 19 : 18;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_ADD, ST_RECIP, ST_REM, ST_EST,
    ST_CHK, ST_MUL3, ST_START2, ST_WAIT2, ST_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  n_r;
  logic [SUM_W-1:0]  s_r;
  logic [7:0]        d_r;
  logic [IDLE_W-1:0] idle16_r;
  logic [CF_W-1:0]   cf_r;
  logic [P1_W-1:0]   p1_r;
  logic [P2_W-1:0]   p2_r;
  logic [NUM_W-1:0]  num_r;
  logic [Q_W-1:0]    q0_r;
  logic [17:0]       rem_r;
  logic [17:0]       est_r;
  logic [19:0]       diff_r;
  logic [N2_W-1:0]   num2_r;
  logic [7:0]        allowed_r;
  logic              res_valid_r;
  out_item_t         res_r;

  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DEN_W-1:0]  div_dsr;
  logic [CMP_W-1:0]  b16, idle_ext, diff_full;
  logic [7:0]        q_cap;
  logic [RP_W-1:0]   recip_prod;
  logic [17:0]       rem_prod;
  logic [Q_W-1:0]    q_fix;

  assign div_start = (state_r == ST_START2);
  assign div_dvd   = num2_r;
  assign div_dsr   = cf_r;

  lfpl_div #(
    .DVD_W(DVD_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dsr),
    .done    (div_done),
    .quotient(div_q)
  );

  // estimate divide by 16 * 65025: drop four bits, then a reciprocal multiply on the
  // upper part; the remainder is below 3 * 65025, so its low 18 bits are exact
  assign recip_prod = RP_W'(num_r[NUM_W-1:20]) * RP_W'(EST_RECIP);
  assign rem_prod   = q0_r[17:0] * 18'(SCALE2);
  assign q_fix      = q0_r + ((rem_r >= SCALE2_X2) ? Q_W'(2) :
                              (rem_r >= 18'(SCALE2)) ? Q_W'(1) : Q_W'(0));

  assign b16       = CMP_W'({cfg.budget_ma, 4'b0000});
  assign idle_ext  = CMP_W'(idle16_r);
  assign diff_full = b16 - idle_ext;
  assign q_cap     = (div_q > DVD_W'(MAX_BRIGHT)) ? MAX_BRIGHT : div_q[7:0];

  assign job_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_pop && state_r != ST_OUT) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            n_r     <= job_n;
            s_r     <= job_s;
            d_r     <= job_d;
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          idle16_r <= IDLE_W'(n_r) * IDLE_W'(cfg.idle_current_per_led);
          cf_r     <= CF_W'(s_r) * CF_W'(cfg.channel_full_current);
          state_r  <= ST_MUL2;
        end
        ST_MUL2: begin
          p1_r    <= P1_W'(idle16_r) * P1_W'(SCALE2);
          p2_r    <= P2_W'(cf_r) * P2_W'(d_r);
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          // adding half the divisor turns the floor division into round half up
          num_r   <= NUM_W'(p1_r) + NUM_W'(p2_r) + NUM_W'(EST_HALF);
          state_r <= ST_RECIP;
        end
        ST_RECIP: begin
          q0_r    <= Q_W'(recip_prod[RP_W-1:24]);
          state_r <= ST_REM;
        end
        ST_REM: begin
          rem_r   <= num_r[21:4] - rem_prod;
          state_r <= ST_EST;
        end
        ST_EST: begin
          est_r   <= (q_fix > Q_W'(EST_MAX)) ? EST_MAX : q_fix[17:0];
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          priority if (est_r <= 18'(cfg.budget_ma) || cf_r == '0) begin
            allowed_r <= d_r;
            state_r   <= ST_OUT;
          end else if (b16 <= idle_ext) begin
            allowed_r <= '0;
            state_r   <= ST_OUT;
          end else begin
            diff_r  <= diff_full[19:0];
            state_r <= ST_MUL3;
          end
        end
        ST_MUL3: begin
          num2_r  <= N2_W'(diff_r) * N2_W'(SCALE2);
          state_r <= ST_START2;
        end
        ST_START2: begin
          state_r <= ST_WAIT2;
        end
        ST_WAIT2: begin
          if (div_done) begin
            allowed_r <= (q_cap > d_r) ? d_r : q_cap;
            state_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_valid_r || res_pop) begin
            res_valid_r              <= 1'b1;
            res_r.allowed_brightness <= allowed_r;
            res_r.estimated_ma       <= est_r;
            res_r.was_clamped        <= (allowed_r < d_r);
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res_item  = res_r;

`ifndef SYNTHESIS
  a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_WAIT2))
    else $error("divider finished with no one waiting");

  a_scale_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START2) |-> (cf_r != '0))
    else $error("brightness division by zero colour current");

  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid_r) |-> (res_r.was_clamped == (res_r.allowed_brightness < d_r)))
    else $error("clamp flag disagrees with brightness");

  a_allowed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (allowed_r <= d_r))
    else $error("allowed brightness above desired");
`endif

endmodule

@@ hdl/led_frame_power_limiter_core.sv @@
`timescale 1ns / 1ps

// LED frame power limiter. Pixels stream in one per cycle on the in_ queue port while it
// is not full; the front end sums all colour channels and counts pixels (pixels past
// MAX_PIXELS in a frame are dropped), and on the last pixel of a frame hands the totals to
// a two-entry job queue. The back end works one frame at a time: two multiply stages, a
// rounding add, then a reciprocal multiply with a remainder correction for the current
// estimate, then, only when the budget is exceeded with colour lit, a bit-serial divide
// for the brightness that gives one quotient bit per cycle for its 36 dividend bits.
// Pixels keep flowing while the back end works; the input reports full only when two
// finished frames are queued. Each frame gives one result word, held in an output register
// until popped. Configuration writes are always ready and should be made while no frame is
// in flight.

module led_frame_power_limiter_core #(
  parameter int MAX_PIXELS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  lfpl_pkg::in_item_t              in_item,
  output logic                            out_empty,
  input  logic                            out_pop,
  output lfpl_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfpl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfpl_pkg::*;

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W = $clog2(765 * MAX_PIXELS + 1);

  cfg_t             cfg_r;
  logic             job_valid, job_ready, res_valid;
  logic [CNT_W-1:0] job_n;
  logic [SUM_W-1:0] job_s;
  logic [7:0]       job_d;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.budget_ma            <= RST_BUDGET;
      cfg_r.channel_full_current <= RST_CHAN_FULL;
      cfg_r.idle_current_per_led <= RST_IDLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUDGET:    cfg_r.budget_ma            <= cfg_data;
        REG_CHAN_FULL: cfg_r.channel_full_current <= cfg_data[9:0];
        REG_IDLE:      cfg_r.idle_current_per_led <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  lfpl_front #(
    .MAX_PIXELS(MAX_PIXELS),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job_n    (job_n),
    .job_s    (job_s),
    .job_d    (job_d)
  );

  lfpl_back #(
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job_n    (job_n),
    .job_s    (job_s),
    .job_d    (job_d),
    .res_valid(res_valid),
    .res_pop  (out_pop),
    .res_item (out_item)
  );

  assign out_empty = !res_valid;

endmodule

@@ tb/sv/led_frame_power_limiter_core_tb.sv @@
`timescale 1ns / 1ps

module led_frame_power_limiter_core_tb;
  import lfpl_pkg::*;

  localparam int MAX_PIXELS    = 1024;
  localparam int SETTLE_CYCLES = 120;
  localparam int TAIL_CYCLES   = 150;
  localparam int RANDOM_PIXELS = 30;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_item_t              in_item;
  logic                  out_empty;
  logic                  out_pop;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow of the limiter registers and frame accumulators
  logic [15:0] budget_reg;
  logic [9:0]  chan_full_reg;
  logic [7:0]  idle_reg;
  logic [19:0] frame_sum;
  logic [10:0] frame_pixels;

  out_item_t pending_results[$];
  int        mismatches;
  int        pixels_sent;
  int        burst_left;
  int        rx_hold_req;

  led_frame_power_limiter_core #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // brightness limit for a finished frame of n pixels with channel sum s
  function automatic out_item_t limit_brightness(input logic [10:0] n, input logic [19:0] s,
                                                 input logic [7:0] d);
    logic [63:0] idle16;
    logic [63:0] lit;
    logic [63:0] num;
    logic [63:0] est;
    logic [63:0] bright;
    out_item_t   r;
    idle16 = n * idle_reg;
    lit    = s * chan_full_reg;
    num    = idle16 * SCALE2 + lit * d;
    est    = (64'd2 * num + EST_DEN) / (64'd2 * EST_DEN);
    if (est > EST_MAX)
      est = EST_MAX;
    if (est <= budget_reg || lit == 0) begin
      bright = d;
    end else if (64'd16 * budget_reg <= idle16) begin
      bright = 0;
    end else begin
      bright = ((64'd16 * budget_reg - idle16) * SCALE2) / lit;
      if (bright > MAX_BRIGHT)
        bright = MAX_BRIGHT;
      if (bright > d)
        bright = d;
    end
    r.allowed_brightness = bright[7:0];
    r.estimated_ma       = est[17:0];
    r.was_clamped        = (bright < d);
    return r;
  endfunction

  function automatic void track_pixel(input in_item_t w);
    if (frame_pixels < MAX_PIXELS) begin
      frame_sum    = frame_sum + w.pixel_color[23:16] + w.pixel_color[15:8]
                     + w.pixel_color[7:0];
      frame_pixels = frame_pixels + 11'd1;
    end
    if (w.last_pixel) begin
      pending_results.push_back(limit_brightness(frame_pixels, frame_sum,
                                                 w.desired_brightness));
      frame_sum    = '0;
      frame_pixels = '0;
    end
  endfunction

  function automatic logic [23:0] random_color();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom_range(0, 255)) << (8 * $urandom_range(0, 2));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_bright();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return MAX_BRIGHT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [23:0] color, input logic last, input logic [7:0] d);
    in_item_t w;
    int       gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    w.pixel_color        = color;
    w.last_pixel         = last;
    w.desired_brightness = d;
    in_item <= w;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    burst_left--;
    pixels_sent++;
    track_pixel(w);
  endtask

  task automatic send_frame(input int len, input logic [7:0] d);
    for (int k = 0; k < len - 1; k++)
      send_pixel(random_color(), 1'b0, random_bright());
    send_pixel(random_color(), 1'b1, d);
  endtask

  // drain every pending result, then give the back end time to go quiet
  task automatic settle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BUDGET:    budget_reg    = data;
      REG_CHAN_FULL: chan_full_reg = data[9:0];
      REG_IDLE:      idle_reg      = data[7:0];
      default:       ;
    endcase
  endtask

  // upper data bits carry junk that the registers must drop
  task automatic set_config(input logic [15:0] b, input logic [9:0] c, input logic [7:0] i);
    logic [5:0] junk6;
    logic [7:0] junk8;
    junk6 = 6'($urandom_range(0, 63));
    junk8 = 8'($urandom_range(0, 255));
    settle();
    write_reg(REG_BUDGET, b);
    write_reg(REG_CHAN_FULL, {junk6, c});
    write_reg(REG_IDLE, {junk8, i});
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing pending", got));
    end else begin
      want = pending_results.pop_front();
      if (got.allowed_brightness !== want.allowed_brightness)
        report_mismatch($sformatf("allowed_brightness got %0d want %0d",
                                  got.allowed_brightness, want.allowed_brightness));
      if (got.estimated_ma !== want.estimated_ma)
        report_mismatch($sformatf("estimated_ma got %0d want %0d",
                                  got.estimated_ma, want.estimated_ma));
      if (got.was_clamped !== want.was_clamped)
        report_mismatch($sformatf("was_clamped got %0b want %0b",
                                  got.was_clamped, want.was_clamped));
    end
  endtask

  // result side: a rotating stall pattern that is periodically reloaded, plus long holds on request
  initial begin
    int         hold_left;
    int         cyc;
    logic [7:0] pop_pattern;
    hold_left   = 0;
    cyc         = 0;
    pop_pattern = 8'hFF;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        check_result(out_item);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      cyc++;
      if (cyc % 64 == 0)
        pop_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      else
        pop_pattern = {pop_pattern[6:0], pop_pattern[7]};
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= pop_pattern[0];
      end
    end
  end

  task automatic test_directed();
    // reset values: fits the budget
    send_pixel(24'hFFFFFF, 1'b1, 8'd255);
    send_pixel(24'h000000, 1'b0, 8'd13);
    send_pixel(24'h123456, 1'b0, 8'd200);
    send_pixel(24'hFF0000, 1'b1, 8'd0);
    // zero budget: dark frame passes, lit frame is idle over budget
    set_config(16'd0, 10'd320, 8'd16);
    send_pixel(24'h000000, 1'b1, 8'd255);
    send_pixel(24'hFFFFFF, 1'b1, 8'd128);
    // tight budget: scaled brightness, and one frame that still fits
    set_config(16'd30, 10'd320, 8'd16);
    send_pixel(24'hFFFFFF, 1'b1, 8'd255);
    send_pixel(24'hFFFFFF, 1'b1, 8'd100);
    send_pixel(24'h00FF00, 1'b0, 8'd1);
    send_pixel(24'h0000FF, 1'b0, 8'd2);
    send_pixel(24'h808080, 1'b1, 8'd200);
    set_config(16'hFFFF, 10'h3FF, 8'hFF);
    send_pixel(24'hFFFFFF, 1'b0, 8'hAA);
    send_pixel(24'hFFFFFF, 1'b0, 8'h55);
    send_pixel(24'hFFFFFF, 1'b1, 8'd255);
    // no channel current: over budget from idle but nothing lit
    set_config(16'd0, 10'd0, 8'hFF);
    send_pixel(24'hFFFFFF, 1'b1, 8'd77);
    send_pixel(24'h7F7F7F, 1'b1, 8'd0);
  endtask

  task automatic test_frame_overflow();
    set_config(16'd3000, 10'd320, 8'd16);
    send_frame(MAX_PIXELS + 3, random_bright());
    send_frame(2, random_bright());
  endtask

  task automatic test_output_backpressure();
    set_config(16'd40, 10'd500, 8'd20);
    rx_hold_req = 400;
    repeat (12) send_frame(1, random_bright());
  endtask

  task automatic test_random_frames();
    int          start;
    int          phase;
    int          frames;
    int          len;
    logic [15:0] b;
    logic [9:0]  c;
    logic [7:0]  i;
    start = pixels_sent;
    phase = 0;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      case (phase)
        0: set_config(16'hFFFF, 10'h3FF, 8'hFF);
        1: set_config(16'd0, 10'd0, 8'd0);
        2: set_config(16'd1, 10'h3FF, 8'd0);
        default: begin
          case ($urandom_range(0, 4))
            0:       b = 16'd0;
            1:       b = 16'hFFFF;
            2:       b = 16'($urandom_range(0, 100));
            3:       b = 16'($urandom_range(0, 2000));
            default: b = 16'($urandom_range(0, 65535));
          endcase
          case ($urandom_range(0, 3))
            0:       c = 10'd0;
            1:       c = 10'h3FF;
            default: c = 10'($urandom_range(0, 1023));
          endcase
          case ($urandom_range(0, 3))
            0:       i = 8'd0;
            1:       i = 8'hFF;
            default: i = 8'($urandom_range(0, 255));
          endcase
          set_config(b, c, i);
        end
      endcase
      phase++;
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(5, 12);
          default: len = $urandom_range(1, 2);
        endcase
        send_frame(len, random_bright());
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_push       <= 1'b0;
    in_item       <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    budget_reg    = RST_BUDGET;
    chan_full_reg = RST_CHAN_FULL;
    idle_reg      = RST_IDLE;
    frame_sum     = '0;
    frame_pixels  = '0;
    mismatches    = 0;
    pixels_sent   = 0;
    burst_left    = 0;
    rx_hold_req   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_frame_overflow();
    test_output_backpressure();
    test_random_frames();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ led_frame_power_limiter_core.f @@
hdl/lfpl_pkg.sv
hdl/lfpl_div.sv
hdl/lfpl_front.sv
hdl/lfpl_back.sv
hdl/led_frame_power_limiter_core.sv
tb/sv/led_frame_power_limiter_core_tb.sv
